// File: design/mlt_pkg.sv
package mlt_pkg;

  localparam int unsigned Buckets     = 256;
  localparam int unsigned Ways        = 4;
  localparam int unsigned PortBits    = 6;
  localparam int unsigned BucketBits  = $clog2(Buckets);
  localparam int unsigned WayBits     = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned KeyBits     = 48;
  localparam int unsigned TimeBits    = 32;
  localparam int unsigned CountBits   = 11;
  localparam int unsigned OutPortBits = 6;
  localparam logic [TimeBits-1:0] AgeingReset = TimeBits'(300);

  typedef enum logic [1:0] {
    OP_LEARN  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_TICK   = 2'd2,
    OP_AGE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_SWEEP_RD,
    ST_SWEEP_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic issue_read;
    logic do_update;
    logic do_tick;
    logic sweep_start;
    logic sweep_read;
    logic sweep_write;
    logic capture;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
  } ctrl_sts_t;

  typedef struct packed {
    logic [KeyBits-1:0]  key;
    logic [PortBits-1:0] port;
    logic [TimeBits-1:0] seen;
  } entry_t;

endpackage

// File: design/mlt_ctrl.sv
module mlt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  logic [1:0]         in_op_i,
  input  logic               out_free_i,
  input  mlt_pkg::ctrl_sts_t sts_i,
  output mlt_pkg::ctrl_cmd_t cmd_o,
  output logic               busy_o
);
  import mlt_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          case (op_e'(in_op_i))
            OP_LEARN, OP_LOOKUP: state_d = ST_READ;
            OP_TICK:             state_d = ST_DONE;
            OP_AGE:              state_d = ST_SWEEP_RD;
            default:             state_d = ST_DONE;
          endcase
        end
      end
      ST_READ:     state_d = ST_UPDATE;
      ST_UPDATE:   state_d = ST_DONE;
      ST_SWEEP_RD: state_d = ST_SWEEP_WR;
      ST_SWEEP_WR: state_d = sts_i.sweep_last ? ST_DONE : ST_SWEEP_RD;
      ST_DONE:     if (out_free_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        cmd_o.issue_read  = in_fire_i;
        cmd_o.do_tick     = in_fire_i && (op_e'(in_op_i) == OP_TICK);
        cmd_o.sweep_start = in_fire_i && (op_e'(in_op_i) == OP_AGE);
      end
      ST_UPDATE:   cmd_o.do_update = 1'b1;
      ST_SWEEP_RD: cmd_o.sweep_read = 1'b1;
      ST_SWEEP_WR: cmd_o.sweep_write = 1'b1;
      ST_DONE:     cmd_o.capture = out_free_i;
      default:     cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_sweep_only_from_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SWEEP_WR |-> $past(state_q) == ST_SWEEP_RD) else $error("sweep order");
  a_update_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPDATE |-> $past(state_q) == ST_READ) else $error("update order");
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !cmd_o.issue_read) else $error("accept while busy");

endmodule

// File: design/mlt_dpath.sv
module mlt_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mlt_pkg::ctrl_cmd_t                cmd_i,
  output mlt_pkg::ctrl_sts_t                sts_o,
  input  logic [1:0]                        in_op_i,
  input  logic [mlt_pkg::KeyBits-1:0]       in_key_i,
  input  logic [5:0]                        in_port_i,
  input  logic [mlt_pkg::TimeBits-1:0]      ageing_limit_i,
  output logic                              res_hit_o,
  output logic [mlt_pkg::OutPortBits-1:0]   res_port_o,
  output logic                              res_ins_o,
  output logic                              res_drop_o,
  output logic [mlt_pkg::CountBits-1:0]     res_removed_o,
  output logic [mlt_pkg::CountBits-1:0]     res_total_o
);
  import mlt_pkg::*;

  entry_t mem_q [Ways][Buckets];
  entry_t rd_q [Ways];
  logic [Ways-1:0] valid_q [Buckets];
  logic [Ways-1:0] vrd_q;

  logic [1:0]            op_q;
  logic [KeyBits-1:0]    key_q;
  logic [PortBits-1:0]   port_q;
  logic [BucketBits-1:0] bkt_q;
  logic [TimeBits-1:0]   now_q;
  logic [CountBits-1:0]  total_q, removed_q;
  logic                  hit_q, ins_q, drop_q;
  logic [OutPortBits-1:0] fport_q;

  logic [BucketBits-1:0] rd_addr;
  assign rd_addr = cmd_i.issue_read ? in_key_i[BucketBits-1:0] : bkt_q;

  logic [Ways-1:0] match, free;
  logic            any_match, any_free;
  logic [WayBits-1:0] match_way, free_way;
  always_comb begin
    any_match = 1'b0;
    any_free  = 1'b0;
    match_way = '0;
    free_way  = '0;
    for (int w = Ways - 1; w >= 0; w--) begin
      match[w] = vrd_q[w] && (rd_q[w].key == key_q);
      free[w]  = !vrd_q[w];
      if (match[w]) begin
        any_match = 1'b1;
        match_way = WayBits'(w);
      end
      if (free[w]) begin
        any_free = 1'b1;
        free_way = WayBits'(w);
      end
    end
  end

  logic [Ways-1:0] expire;
  logic [$clog2(Ways+1)-1:0] expire_n;
  always_comb begin
    expire_n = '0;
    for (int w = 0; w < Ways; w++) begin
      expire[w] = vrd_q[w] && ((now_q - rd_q[w].seen) > ageing_limit_i);
      expire_n = expire_n + ($clog2(Ways+1))'(expire[w]);
    end
  end

  assign sts_o.sweep_last = (bkt_q == BucketBits'(Buckets - 1));

  logic        wr_en;
  logic [WayBits-1:0] wr_way;
  assign wr_en  = cmd_i.do_update && (op_e'(op_q) == OP_LEARN) && (any_match || any_free);
  assign wr_way = any_match ? match_way : free_way;

  always_ff @(posedge clk_i) begin
    for (int w = 0; w < Ways; w++) begin
      rd_q[w] <= mem_q[w][rd_addr];
      if (wr_en && wr_way == WayBits'(w)) begin
        mem_q[w][bkt_q] <= '{key: key_q, port: port_q, seen: now_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < Buckets; b++) valid_q[b] <= '0;
      vrd_q     <= '0;
      now_q     <= '0;
      total_q   <= '0;
      removed_q <= '0;
      hit_q     <= 1'b0;
      ins_q     <= 1'b0;
      drop_q    <= 1'b0;
      fport_q   <= '0;
      op_q      <= '0;
      bkt_q     <= '0;
      key_q     <= '0;
      port_q    <= '0;
    end else begin
      vrd_q <= valid_q[rd_addr];
      if (cmd_i.issue_read) begin
        op_q      <= in_op_i;
        key_q     <= in_key_i;
        port_q    <= in_port_i[PortBits-1:0];
        bkt_q     <= cmd_i.sweep_start ? '0 : in_key_i[BucketBits-1:0];
        hit_q     <= 1'b0;
        ins_q     <= 1'b0;
        drop_q    <= 1'b0;
        fport_q   <= '0;
        removed_q <= '0;
      end
      if (cmd_i.do_tick) now_q <= now_q + 1'b1;
      if (cmd_i.do_update) begin
        if (op_e'(op_q) == OP_LEARN) begin
          hit_q  <= any_match;
          ins_q  <= !any_match && any_free;
          drop_q <= !any_match && !any_free;
          if (!any_match && any_free) begin
            valid_q[bkt_q][free_way] <= 1'b1;
            total_q <= total_q + 1'b1;
          end
        end else begin
          hit_q   <= any_match;
          fport_q <= any_match ? OutPortBits'(rd_q[match_way].port) : '0;
        end
      end
      if (cmd_i.sweep_write) begin
        valid_q[bkt_q] <= valid_q[bkt_q] & ~expire;
        removed_q <= removed_q + CountBits'(expire_n);
        total_q   <= total_q - CountBits'(expire_n);
        bkt_q     <= bkt_q + 1'b1;
      end
    end
  end

  assign res_hit_o     = hit_q;
  assign res_port_o    = fport_q;
  assign res_ins_o     = ins_q;
  assign res_drop_o    = drop_q;
  assign res_removed_o = removed_q;
  assign res_total_o   = total_q;

  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({ins_q, drop_q, hit_q}) <= 1) else $error("learn outcome");
  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ins_q) |-> total_q == $past(total_q) + 1'b1) else $error("count");
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CountBits'(Buckets * Ways)) else $error("total");

endmodule

// File: design/mac_learning_table_with_ageing.sv
// Learn and lookup go through read, update and done states; a tick goes straight to
// done; an ageing sweep reads and writes back every bucket in turn, then goes to done.
// One item at a time: done waits for a free output slot, then a new item is taken.
// Reset (async, active low) clears all entry valid bits, the time counter and
// the entry count; the ageing limit resets to 300.
module mac_learning_table_with_ageing (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // opcode[1:0], mac_address[49:2], port_number[55:50]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // hit, found_port, inserted, dropped_full,
                                     // removed_count, entry_count
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);
  import mlt_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic busy, in_fire, out_free;
  logic [TimeBits-1:0] limit_q;
  logic hit, ins, drop;
  logic [OutPortBits-1:0] fport;
  logic [CountBits-1:0] removed, total;
  logic ovalid_q;
  logic [31:0] odata_q;

  assign s_axis_tready = !busy;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= AgeingReset;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  mlt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .in_op_i(s_axis_tdata[1:0]),
    .out_free_i(out_free), .sts_i(sts), .cmd_o(cmd), .busy_o(busy)
  );

  mlt_dpath u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .in_op_i(s_axis_tdata[1:0]), .in_key_i(s_axis_tdata[49:2]),
    .in_port_i(s_axis_tdata[55:50]), .ageing_limit_i(limit_q),
    .res_hit_o(hit), .res_port_o(fport), .res_ins_o(ins), .res_drop_o(drop),
    .res_removed_o(removed), .res_total_o(total)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd.capture) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.capture) odata_q <= {1'b0, total, removed, drop, ins, fport, hit};
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

endmodule
